// File: src/voice_adsr_gate_glide_macros.svh
// Assertion macros for the voice envelope block.
// Used by the port checker; expects clk and rst_n in scope.
`ifndef VOICE_ADSR_GATE_GLIDE_MACROS_SVH
`define VOICE_ADSR_GATE_GLIDE_MACROS_SVH

// same-cycle implication
`define VAGG_ASSERT_IMP(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("voice envelope check failed");

// next-cycle implication
`define VAGG_ASSERT_NEXT(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("voice envelope check failed");

`endif

// File: src/vagg_pkg.sv
// Shared types and constants for the voice envelope block.
// No dependencies.
`default_nettype none

package vagg_pkg;

  localparam int VOICE_COUNT_DEF = 8;

  localparam int IN_TDATA_W  = 48;
  localparam int IN_TUSER_W  = 3;
  localparam int OUT_TDATA_W = 80;
  localparam int OUT_TUSER_W = 3;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 24;

  localparam logic [23:0] AMP_ONE     = 24'd8388608;
  localparam logic [23:0] PITCH_RESET = 24'd112640;

  localparam logic [2:0] PH_IDLE    = 3'd0;
  localparam logic [2:0] PH_ATTACK  = 3'd1;
  localparam logic [2:0] PH_DECAY   = 3'd2;
  localparam logic [2:0] PH_SUSTAIN = 3'd3;
  localparam logic [2:0] PH_RELEASE = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_ATTACK  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DECAY   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SUSTAIN = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SMOOTH  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_GLIDE   = 3'd5;

  localparam logic [23:0] ATTACK_DEF  = 24'd8388608;
  localparam logic [23:0] DECAY_DEF   = 24'd8388608;
  localparam logic [23:0] RELEASE_DEF = 24'd8388608;
  localparam logic [23:0] SUSTAIN_DEF = 24'd8388608;
  localparam logic [15:0] SMOOTH_DEF  = 16'd58982;
  localparam logic [23:0] GLIDE_DEF   = 24'd7609;

  typedef struct packed {
    logic [2:0]  phase;
    logic [23:0] amp;
    logic [23:0] smooth;
    logic [19:0] gate_left;
    logic        gate_open;
    logic [23:0] pitch;
    logic [23:0] goal;
    logic [15:0] glide_cnt;
    logic        glide_on;
  } voice_rec_t;

  localparam voice_rec_t VOICE_REC_RESET = '{
    phase:     PH_IDLE,
    amp:       24'd0,
    smooth:    24'd0,
    gate_left: 20'd0,
    gate_open: 1'b0,
    pitch:     PITCH_RESET,
    goal:      PITCH_RESET,
    glide_cnt: 16'd0,
    glide_on:  1'b0
  };

endpackage

`default_nettype wire

// File: src/vagg_vstore.sv
// Per-voice state store: one record per voice, registered read.
// Entries never written read as the reset record. Uses vagg_pkg.
`default_nettype none

module vagg_vstore #(
  parameter int VOICE_COUNT = vagg_pkg::VOICE_COUNT_DEF,
  parameter int VIW = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic [VIW-1:0]      rd_addr,
  output vagg_pkg::voice_rec_t     rd_data,
  input  wire logic                wr_en,
  input  wire logic [VIW-1:0]      wr_addr,
  input  wire vagg_pkg::voice_rec_t wr_data
);
  import vagg_pkg::*;

  voice_rec_t               mem [VOICE_COUNT];
  logic [VOICE_COUNT-1:0]   valid_r;
  voice_rec_t               rd_data_r;
  logic                     rd_valid_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
      rd_valid_r <= valid_r[rd_addr];
    end
  end

  assign rd_data = rd_valid_r ? rd_data_r : VOICE_REC_RESET;

endmodule

`default_nettype wire

// File: src/voice_adsr_gate_glide.sv
// Multi-voice linear ADSR with gate countdown, pitch glide and smoothing.
// Uses vagg_pkg and vagg_vstore.
//
//  channel | ports                          | word
//  in      | in_tvalid/in_tready/tdata/tuser| tuser voice; tdata trig, glide, gate, pitch
//  out     | out_tvalid/out_tready/tdata/tuser | tuser voice; tdata env, smooth, pitch...
//  cfg     | cfg_valid/cfg_ready/index/data | register write, always ready
//
// Steps: read, load, glide, envelope, smoothing, write-back. Glide is skipped
// when no glide is moving and cut short when it lands; smoothing is skipped when
// the voice ends idle; a voice index at or beyond VOICE_COUNT goes to write-back.
// The one shared 24x25 multiplier is stepped through glide and smoothing by the sequencer.
// Reset: synchronous, active low; all voices idle at 440 Hz.
// Stalls: a finished word waits in the output register; the next input word
// is taken meanwhile and holds at write-back until the output is free.
`default_nettype none

module voice_adsr_gate_glide #(
  parameter int VOICE_COUNT = vagg_pkg::VOICE_COUNT_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  // [0] note_trigger, [1] glide_request, [21:2] gate_samples,
  // [45:22] target_pitch, [47:46] zero
  input  wire logic [vagg_pkg::IN_TDATA_W-1:0]    in_tdata,
  // [2:0] voice_sel
  input  wire logic [vagg_pkg::IN_TUSER_W-1:0]    in_tuser,
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  // [23:0] env_level, [47:24] smooth_level, [71:48] pitch_now,
  // [74:72] env_phase, [75] sounding, [79:76] zero
  output logic [vagg_pkg::OUT_TDATA_W-1:0]        out_tdata,
  // [2:0] voice_out
  output logic [vagg_pkg::OUT_TUSER_W-1:0]        out_tuser,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [vagg_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [vagg_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import vagg_pkg::*;

  localparam int VIW = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_READ = 4'd1;
  localparam logic [3:0] S_LOAD = 4'd2;
  localparam logic [3:0] S_GL1  = 4'd3;
  localparam logic [3:0] S_GL2  = 4'd4;
  localparam logic [3:0] S_GL3  = 4'd5;
  localparam logic [3:0] S_ENV  = 4'd6;
  localparam logic [3:0] S_SM1  = 4'd7;
  localparam logic [3:0] S_SM2  = 4'd8;
  localparam logic [3:0] S_SM3  = 4'd9;
  localparam logic [3:0] S_WR   = 4'd10;

  logic [3:0]  state_r, state_nxt;

  logic [23:0] attack_r, decay_r, release_r, sustain_r, glide_rate_r;
  logic [15:0] coeff_r;

  logic [2:0]  voice_r;
  logic        trig_r, glide_req_r, in_range_r;
  logic [19:0] gate_r;
  logic [23:0] target_r;

  voice_rec_t  w_r, w_nxt, rd_rec;
  logic        dir_r, dir_nxt;
  logic [23:0] mul_a;
  logic [24:0] mul_b;
  logic [48:0] mul_p_r;
  logic [40:0] acc_r, acc_nxt;

  logic        out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r;
  logic [2:0]  out_user_r;

  logic        in_acc, out_load, wr_en;
  logic        in_range_in;
  logic [23:0] sus;
  logic [15:0] cnt_inc;
  logic [39:0] t_val;
  logic [47:0] mv_sum;
  logic [24:0] add_sum;
  logic [40:0] sm_sum;

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;
  assign in_range_in = ({4'd0, in_tuser[2:0]} < 7'(VOICE_COUNT));
  assign out_load  = (state_r == S_WR) && (!out_valid_r || out_tready);
  assign wr_en     = out_load && in_range_r;

  vagg_vstore #(
    .VOICE_COUNT (VOICE_COUNT),
    .VIW         (VIW)
  ) u_vstore (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_addr (VIW'(voice_r)),
    .rd_data (rd_rec),
    .wr_en   (wr_en),
    .wr_addr (VIW'(voice_r)),
    .wr_data (w_r)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attack_r     <= ATTACK_DEF;
      decay_r      <= DECAY_DEF;
      release_r    <= RELEASE_DEF;
      sustain_r    <= SUSTAIN_DEF;
      coeff_r      <= SMOOTH_DEF;
      glide_rate_r <= GLIDE_DEF;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_ATTACK:  attack_r     <= cfg_data;
        REG_DECAY:   decay_r      <= cfg_data;
        REG_RELEASE: release_r    <= cfg_data;
        REG_SUSTAIN: sustain_r    <= cfg_data;
        REG_SMOOTH:  coeff_r      <= cfg_data[15:0];
        REG_GLIDE:   glide_rate_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign sus     = (sustain_r > AMP_ONE) ? AMP_ONE : sustain_r;
  assign cnt_inc = (w_r.glide_cnt == 16'hFFFF) ? w_r.glide_cnt : w_r.glide_cnt + 16'd1;
  assign t_val   = mul_p_r[39:0];
  assign mv_sum  = mul_p_r[47:0] + 48'h80_0000;
  assign sm_sum  = acc_r + mul_p_r[40:0] + 41'd32768;

  always_comb begin
    state_nxt = state_r;
    w_nxt     = w_r;
    dir_nxt   = dir_r;
    acc_nxt   = acc_r;
    mul_a     = w_r.smooth;
    mul_b     = {9'd0, coeff_r};
    add_sum   = {1'b0, w_r.amp} + {1'b0, attack_r};
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = in_range_in ? S_READ : S_WR;
        end
      end
      S_READ: state_nxt = S_LOAD;
      S_LOAD: begin
        w_nxt = rd_rec;
        if (trig_r) begin
          w_nxt.gate_left = gate_r;
          w_nxt.gate_open = 1'b1;
          w_nxt.goal      = target_r;
          w_nxt.glide_cnt = 16'd0;
          if (glide_req_r && rd_rec.phase != PH_IDLE) begin
            w_nxt.glide_on = 1'b1;
          end else begin
            w_nxt.pitch    = target_r;
            w_nxt.glide_on = 1'b0;
            w_nxt.amp      = 24'd0;
            w_nxt.phase    = PH_ATTACK;
          end
        end
        if (w_nxt.gate_open) begin
          if (w_nxt.gate_left <= 20'd1) begin
            w_nxt.gate_left = 20'd0;
            w_nxt.gate_open = 1'b0;
            w_nxt.phase     = PH_RELEASE;
          end else begin
            w_nxt.gate_left = w_nxt.gate_left - 20'd1;
          end
        end
        state_nxt = S_GL1;
      end
      S_GL1: begin
        if (w_r.glide_on) begin
          w_nxt.glide_cnt = cnt_inc;
          mul_a     = {8'd0, cnt_inc};
          mul_b     = {1'b0, glide_rate_r};
          state_nxt = S_GL2;
        end else begin
          state_nxt = S_ENV;
        end
      end
      S_GL2: begin
        if (|t_val[39:24]) begin
          w_nxt.pitch    = w_r.goal;
          w_nxt.glide_on = 1'b0;
          state_nxt      = S_ENV;
        end else begin
          dir_nxt   = (w_r.goal < w_r.pitch);
          mul_a     = dir_nxt ? (w_r.pitch - w_r.goal) : (w_r.goal - w_r.pitch);
          mul_b     = {1'b0, t_val[23:0]};
          state_nxt = S_GL3;
        end
      end
      S_GL3: begin
        w_nxt.pitch = dir_r ? (w_r.pitch - mv_sum[47:24]) : (w_r.pitch + mv_sum[47:24]);
        state_nxt   = S_ENV;
      end
      S_ENV: begin
        unique case (w_r.phase)
          PH_ATTACK: begin
            if (add_sum >= {1'b0, AMP_ONE}) begin
              w_nxt.amp   = AMP_ONE;
              w_nxt.phase = PH_DECAY;
            end else begin
              w_nxt.amp = add_sum[23:0];
            end
          end
          PH_DECAY: begin
            if ({1'b0, w_r.amp} <= {1'b0, sus} + {1'b0, decay_r}) begin
              w_nxt.amp   = sus;
              w_nxt.phase = PH_SUSTAIN;
            end else begin
              w_nxt.amp = w_r.amp - decay_r;
            end
          end
          PH_SUSTAIN: w_nxt.amp = sus;
          PH_RELEASE: begin
            if (w_r.amp <= release_r) begin
              w_nxt.amp   = 24'd0;
              w_nxt.phase = PH_IDLE;
            end else begin
              w_nxt.amp = w_r.amp - release_r;
            end
          end
          default: ;
        endcase
        state_nxt = S_SM1;
      end
      S_SM1: begin
        mul_a     = w_r.smooth;
        mul_b     = {9'd0, coeff_r};
        state_nxt = (w_r.phase == PH_IDLE) ? S_WR : S_SM2;
      end
      S_SM2: begin
        acc_nxt   = mul_p_r[40:0];
        mul_a     = w_r.amp;
        mul_b     = 25'd65536 - {9'd0, coeff_r};
        state_nxt = S_SM3;
      end
      S_SM3: begin
        w_nxt.smooth = sm_sum[39:16];
        state_nxt    = S_WR;
      end
      S_WR: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      voice_r     <= in_tuser[2:0];
      trig_r      <= in_tdata[0];
      glide_req_r <= in_tdata[1];
      gate_r      <= in_tdata[21:2];
      target_r    <= in_tdata[45:22];
      in_range_r  <= in_range_in;
    end
    w_r     <= w_nxt;
    dir_r   <= dir_nxt;
    acc_r   <= acc_nxt;
    mul_p_r <= {25'd0, mul_a} * {24'd0, mul_b};
    if (out_load) begin
      out_user_r <= voice_r;
      if (in_range_r) begin
        out_data_r <= {4'd0, (w_r.phase != PH_IDLE), w_r.phase,
                       w_r.pitch, w_r.smooth, w_r.amp};
      end else begin
        out_data_r <= '0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

`default_nettype wire

// File: src/vagg_checker.sv
// Port-level checks for the voice envelope block, bound to the top level.
// Uses vagg_pkg and voice_adsr_gate_glide_macros.svh.
`default_nettype none
`include "voice_adsr_gate_glide_macros.svh"

module vagg_checker (
  input wire logic                              clk,
  input wire logic                              rst_n,
  input wire logic                              in_tvalid,
  input wire logic                              in_tready,
  input wire logic                              out_tvalid,
  input wire logic                              out_tready,
  input wire logic [vagg_pkg::OUT_TDATA_W-1:0]  out_tdata
);
  import vagg_pkg::*;

  `VAGG_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid)
  `VAGG_ASSERT_NEXT(a_busy_after_take, in_tvalid && in_tready, !in_tready)
  `VAGG_ASSERT_IMP(a_sounding, out_tvalid, out_tdata[75] == (out_tdata[74:72] != PH_IDLE))
  `VAGG_ASSERT_IMP(a_env_range, out_tvalid, out_tdata[23:0] <= AMP_ONE)
  `VAGG_ASSERT_IMP(a_idle_silent, out_tvalid && (out_tdata[74:72] == PH_IDLE),
                   out_tdata[23:0] == 24'd0)

endmodule

bind voice_adsr_gate_glide vagg_checker u_vagg_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire
